// File: rtl/mpp_pkg.sv
// mpp_pkg: widths, constants, register codes and the queue entry type
// shared by the move planner modules. No dependencies.
package mpp_pkg;

  localparam int TgtW      = 10;
  localparam int SpdW      = 8;
  localparam int PosW      = 15;
  localparam int DistW     = 16;
  localparam int PerW      = 16;
  localparam int CmpW      = 15;
  localparam int SumW      = 33;
  localparam int RadW      = 62;
  localparam int RootW     = 31;
  localparam int DenW      = DistW + SpdW;
  localparam int ScaleW    = 30;
  localparam int DivCntW   = $clog2(PerW);
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 10;
  localparam int InDataW   = 32;
  localparam int OutDataW  = 96;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [PosW-1:0]   StepsPerMm = 15'd25;
  // 28800^2: squared scale of the 1.44 MHz timer, two events per step
  localparam logic [ScaleW-1:0] ScaleSq    = 30'd829440000;

  localparam logic [CfgIdxW-1:0] CfgMaxY     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxZ     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinSpeed = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed = 2'd3;

  localparam logic [TgtW-1:0] RstMaxY     = 10'd300;
  localparam logic [TgtW-1:0] RstMaxZ     = 10'd100;
  localparam logic [SpdW-1:0] RstMinSpeed = 8'd3;
  localparam logic [SpdW-1:0] RstMaxSpeed = 8'd100;

  typedef struct packed {
    logic             acc;
    logic             dir_y;
    logic             dir_z;
    logic [DistW-1:0] dist_y;
    logic [DistW-1:0] dist_z;
    logic [SpdW-1:0]  spd;
  } move_t;

endpackage

// File: rtl/two_axis_stepper_move_planner_core.sv
// Two-axis stepper move planner. Each request on the in_ stream (targets in mm,
// path speed, safety switch) yields one result on the out_ stream: the accepted
// flag in out_tuser, and per axis the direction, doubled step distance, timer
// period and compare value in out_tdata; a rejected request gives all zeros and
// leaves the positions alone. The front checks a request, updates the positions
// and queues it in the same cycle it is taken; it keeps taking requests until
// its two-entry queue is full. The back plans one move at a time, through the
// 31-step square root and the 16-step dividers (both axes divide in parallel);
// a rejected request skips both. Either is held up only while an earlier result
// is still unread on out_. The user is to write limit registers over cfg_
// only while idle; the block does not enforce it. Writes apply to later requests.
module two_axis_stepper_move_planner_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // target_y[9:0], target_z[19:10], speed[27:20], zero fill [31:28]
  input  logic [mpp_pkg::InDataW-1:0]   in_tdata,
  // safety_switch[0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // dir_y[0], dir_z[1], half_steps_y[17:2], half_steps_z[33:18],
  // period_y[49:34], compare_y[64:50], period_z[80:65], compare_z[95:81]
  output logic [mpp_pkg::OutDataW-1:0]  out_tdata,
  // accepted[0]
  output logic                          out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mpp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mpp_pkg::CfgDataW-1:0]  cfg_data
);
  import mpp_pkg::*;

  move_t push_data, pop_data;
  logic  push, pop, full, empty;

  mpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (full),
    .q_push    (push),
    .q_data    (push_data)
  );

  mpp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  mpp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (empty),
    .q_pop      (pop),
    .q_data     (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/mpp_front.sv
// mpp_front: limit registers, request checks, axis positions and step distances.
// Depends on mpp_pkg; feeds mpp_fifo.
module mpp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mpp_pkg::InDataW-1:0]   in_tdata,
  input  logic                          in_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mpp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mpp_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output mpp_pkg::move_t                q_data
);
  import mpp_pkg::*;

  logic [TgtW-1:0] max_y_r, max_z_r;
  logic [SpdW-1:0] min_spd_r, max_spd_r;
  logic [PosW-1:0] pos_y_r, pos_z_r;

  logic [TgtW-1:0] ty, tz;
  logic [SpdW-1:0] spd;
  logic [PosW-1:0] tgt_y, tgt_z;
  logic            ok, dir_y, dir_z;
  logic [DistW-1:0] dist_y, dist_z;

  assign ty  = in_tdata[TgtW-1:0];
  assign tz  = in_tdata[2*TgtW-1:TgtW];
  assign spd = in_tdata[2*TgtW+SpdW-1:2*TgtW];

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;
  assign q_push    = in_tvalid && in_tready;

  assign tgt_y = PosW'(ty) * StepsPerMm;
  assign tgt_z = PosW'(tz) * StepsPerMm;

  assign ok = in_tuser && (ty <= max_y_r) && (tz <= max_z_r) &&
              (spd >= min_spd_r) && (spd <= max_spd_r);

  assign dir_y  = tgt_y > pos_y_r;
  assign dir_z  = tgt_z > pos_z_r;
  assign dist_y = {(dir_y ? tgt_y - pos_y_r : pos_y_r - tgt_y), 1'b0};
  assign dist_z = {(dir_z ? tgt_z - pos_z_r : pos_z_r - tgt_z), 1'b0};

  always_comb begin
    q_data = '0;
    if (ok) begin
      q_data.acc    = 1'b1;
      q_data.dir_y  = dir_y;
      q_data.dir_z  = dir_z;
      q_data.dist_y = dist_y;
      q_data.dist_z = dist_z;
      q_data.spd    = spd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_y_r   <= RstMaxY;
      max_z_r   <= RstMaxZ;
      min_spd_r <= RstMinSpeed;
      max_spd_r <= RstMaxSpeed;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgMaxY:     max_y_r   <= cfg_data[TgtW-1:0];
        CfgMaxZ:     max_z_r   <= cfg_data[TgtW-1:0];
        CfgMinSpeed: min_spd_r <= cfg_data[SpdW-1:0];
        CfgMaxSpeed: max_spd_r <= cfg_data[SpdW-1:0];
      endcase
    end
  end

  // positions move only on a planned request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else if (q_push && ok) begin
      pos_y_r <= tgt_y;
      pos_z_r <= tgt_z;
    end
  end

endmodule

// File: rtl/mpp_fifo.sv
// mpp_fifo: short queue of classified moves between front and back.
// Depends on mpp_pkg (move_t, FifoDepth).
module mpp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mpp_pkg::move_t push_data,
  output logic           full,
  input  logic           pop,
  output mpp_pkg::move_t pop_data,
  output logic           empty
);
  import mpp_pkg::*;

  move_t               ent_r [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FifoCntW-1:0] cnt_r;

  assign full     = cnt_r == FifoCntW'(FifoDepth);
  assign empty    = cnt_r == '0;
  assign pop_data = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) ent_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/mpp_div.sv
// mpp_div: restoring divider, one quotient bit per cycle, result saturated
// to 16 bits (a zero divisor saturates too). Depends on mpp_pkg.
module mpp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mpp_pkg::RootW-1:0]   num,
  input  logic [mpp_pkg::DenW-1:0]    den,
  output logic [mpp_pkg::PerW-1:0]    quo,
  output logic                        done
);
  import mpp_pkg::*;

  localparam int DshW = DenW + PerW;

  logic               busy_r, done_r, sat_r;
  logic [DivCntW-1:0] cnt_r;
  logic [RootW-1:0]   rem_r;
  logic [DshW-1:0]    dsh_r;
  logic [PerW-1:0]    q_r;
  logic               ge;

  assign ge   = DshW'(rem_r) >= dsh_r;
  assign quo  = sat_r ? '1 : q_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DivCntW'(PerW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= DshW'(den) << (PerW - 1);
      q_r   <= '0;
      // quotient would need more than 16 bits
      sat_r <= DshW'(num) >= {den, {PerW{1'b0}}};
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dsh_r[RootW-1:0];
      q_r   <= {q_r[PerW-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

// File: rtl/mpp_back.sv
// mpp_back: takes classified moves from the queue, forms the radicand, runs the
// square root and both period divisions, and holds the result. Uses mpp_div, mpp_pkg.
module mpp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  mpp_pkg::move_t               q_data,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mpp_pkg::OutDataW-1:0] out_tdata,
  output logic                         out_tuser
);
  import mpp_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQA  = 4'd1;
  localparam logic [3:0] ST_SQB  = 4'd2;
  localparam logic [3:0] ST_RLO  = 4'd3;
  localparam logic [3:0] ST_RHI  = 4'd4;
  localparam logic [3:0] ST_ROOT = 4'd5;
  localparam logic [3:0] ST_DGO  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam int PmW = SumW - 16;

  logic [3:0]          state_r;
  logic                out_valid_r, out_user_r;
  logic [OutDataW-1:0] out_data_r;

  move_t            mv_r;
  logic [SumW-1:0]  sum_r;
  logic [DenW-1:0]  dvy_r, dvz_r;
  logic [RadW-1:0]  rad_r, root_r, bit_r;

  logic [DistW-1:0]      sq_op;
  logic [2*DistW-1:0]    sq_w;
  logic [DenW-1:0]       dv_w;
  logic [PmW-1:0]        pm_op;
  logic [PmW+ScaleW-1:0] pm_w;
  logic [RadW-1:0]       trial;
  logic                  div_start, done_y, done_z, out_free;
  logic [PerW-1:0]       per_y, per_z;

  // one shared multiplier for the squares and one for the distance * speed
  assign sq_op = (state_r == ST_SQA) ? mv_r.dist_y : mv_r.dist_z;
  assign sq_w  = (2*DistW)'(sq_op) * (2*DistW)'(sq_op);
  assign dv_w  = DenW'(sq_op) * DenW'(mv_r.spd);
  // radicand built from two partial products of the sum of squares
  assign pm_op = (state_r == ST_RLO) ? sum_r[PmW-1:0] : PmW'(sum_r[SumW-1:PmW]);
  assign pm_w  = (PmW+ScaleW)'(pm_op) * (PmW+ScaleW)'(ScaleSq);
  assign trial = root_r + bit_r;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign div_start = state_r == ST_DGO;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  mpp_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (root_r[RootW-1:0]),
    .den   (dvy_r),
    .quo   (per_y),
    .done  (done_y)
  );

  mpp_div u_div_z (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (root_r[RootW-1:0]),
    .den   (dvz_r),
    .quo   (per_z),
    .done  (done_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // held while unread, loaded when the result register is free
      out_valid_r <= (out_valid_r && !out_tready) || ((state_r == ST_OUT) && out_free);
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) state_r <= q_data.acc ? ST_SQA : ST_OUT;
        end
        ST_SQA:  state_r <= ST_SQB;
        ST_SQB:  state_r <= ST_RLO;
        ST_RLO:  state_r <= ST_RHI;
        ST_RHI:  state_r <= ST_ROOT;
        ST_ROOT: begin
          if (bit_r[0]) state_r <= ST_DGO;
        end
        ST_DGO:  state_r <= ST_DIV;
        ST_DIV: begin
          if (done_y && done_z) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) mv_r <= q_data;
      end
      ST_SQA: begin
        sum_r <= SumW'(sq_w);
        dvy_r <= dv_w;
      end
      ST_SQB: begin
        sum_r <= sum_r + SumW'(sq_w);
        dvz_r <= dv_w;
      end
      ST_RLO: rad_r <= RadW'(pm_w);
      ST_RHI: begin
        rad_r  <= rad_r + RadW'({pm_w, {PmW{1'b0}}});
        root_r <= '0;
        bit_r  <= RadW'(1) << (RadW - 2);
      end
      ST_ROOT: begin
        // one result bit per cycle, two radicand bits per cycle
        if (rad_r >= trial) begin
          rad_r  <= rad_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_OUT: begin
        if (out_free) begin
          out_user_r <= mv_r.acc;
          if (mv_r.acc) begin
            out_data_r <= {per_z[PerW-1:1], per_z, per_y[PerW-1:1], per_y,
                           mv_r.dist_z, mv_r.dist_y, mv_r.dir_z, mv_r.dir_y};
          end else begin
            out_data_r <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/mpp_checker.sv
// mpp_checker: port-level checks of the move planner's result stream,
// bound to two_axis_stepper_move_planner_core. Depends on mpp_pkg.
module mpp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mpp_pkg::OutDataW-1:0]  out_tdata,
  input logic                          out_tuser
);
  import mpp_pkg::*;

  // a stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("rejected move carries nonzero fields");

  a_compare: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[64:50] == out_tdata[49:35] && out_tdata[95:81] == out_tdata[80:66])
    else $error("compare is not half the period");

  // a y axis that does not move never fires and never claims forward motion
  a_idle_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tdata[17:2] == '0 |->
      out_tdata[49:34] == '1 && !out_tdata[0])
    else $error("still axis has a finite period or a direction");

endmodule

bind two_axis_stepper_move_planner_core mpp_checker u_mpp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: sim/move_plan_checker.sv
// move_plan_checker: watches the cfg_, in_ and out_ channels of the move planner,
// predicts each result from its own copy of the limits and axis positions, and
// compares field by field. Depends on mpp_pkg.
`timescale 1ns / 100ps

module move_plan_checker
  import mpp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                out_tuser,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending
);

  typedef struct {
    logic             acc;
    logic             dir_y;
    logic             dir_z;
    logic [DistW-1:0] hs_y;
    logic [DistW-1:0] hs_z;
    logic [PerW-1:0]  per_y;
    logic [CmpW-1:0]  cmp_y;
    logic [PerW-1:0]  per_z;
    logic [CmpW-1:0]  cmp_z;
  } move_result_t;

  logic [TgtW-1:0] lim_y, lim_z;
  logic [SpdW-1:0] lim_spd_lo, lim_spd_hi;
  logic [PosW-1:0] pos_y, pos_z;
  move_result_t    expected_moves[$];

  // bit-by-bit search for the largest root whose square fits
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] root, trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [PerW-1:0] axis_reload(input logic [63:0] root,
                                                  input logic [DistW-1:0] gap_len,
                                                  input logic [SpdW-1:0] spd);
    logic [63:0] den, q;
    den = 64'(gap_len) * 64'(spd);
    if (den == 0) return '1;
    q = root / den;
    return (q > 64'hFFFF) ? '1 : q[PerW-1:0];
  endfunction

  function automatic logic [DistW-1:0] doubled_gap(input logic [PosW-1:0] a,
                                                   input logic [PosW-1:0] b);
    return (a > b) ? {a - b, 1'b0} : {b - a, 1'b0};
  endfunction

  // plans one request against the stored positions and moves them on accept
  function automatic move_result_t plan_move(input logic [TgtW-1:0] ty,
                                             input logic [TgtW-1:0] tz,
                                             input logic [SpdW-1:0] spd,
                                             input logic sw);
    move_result_t r;
    logic [PosW-1:0] new_y, new_z;
    logic [63:0] sq;
    r = '{default: '0};
    if (!sw || ty > lim_y || tz > lim_z || spd < lim_spd_lo || spd > lim_spd_hi)
      return r;
    new_y = PosW'(32'(ty) * 32'(StepsPerMm));
    new_z = PosW'(32'(tz) * 32'(StepsPerMm));
    r.acc   = 1'b1;
    r.dir_y = new_y > pos_y;
    r.dir_z = new_z > pos_z;
    r.hs_y  = doubled_gap(new_y, pos_y);
    r.hs_z  = doubled_gap(new_z, pos_z);
    sq = (64'(r.hs_y) * 64'(r.hs_y) + 64'(r.hs_z) * 64'(r.hs_z)) * 64'(ScaleSq);
    r.per_y = axis_reload(isqrt(sq), r.hs_y, spd);
    r.per_z = axis_reload(isqrt(sq), r.hs_z, spd);
    r.cmp_y = r.per_y[PerW-1:1];
    r.cmp_z = r.per_z[PerW-1:1];
    pos_y = new_y;
    pos_z = new_z;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("%0t ns move check: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_result(input move_result_t e);
    check_field("accepted", 32'(out_tuser), 32'(e.acc));
    check_field("dir_y", 32'(out_tdata[0]), 32'(e.dir_y));
    check_field("dir_z", 32'(out_tdata[1]), 32'(e.dir_z));
    check_field("half_steps_y", 32'(out_tdata[17:2]), 32'(e.hs_y));
    check_field("half_steps_z", 32'(out_tdata[33:18]), 32'(e.hs_z));
    check_field("period_y", 32'(out_tdata[49:34]), 32'(e.per_y));
    check_field("compare_y", 32'(out_tdata[64:50]), 32'(e.cmp_y));
    check_field("period_z", 32'(out_tdata[80:65]), 32'(e.per_z));
    check_field("compare_z", 32'(out_tdata[95:81]), 32'(e.cmp_z));
  endtask

  // one process for all three channels, so limits and positions stay in order
  always @(posedge clk) begin
    if (!rst_n) begin
      lim_y      = RstMaxY;
      lim_z      = RstMaxZ;
      lim_spd_lo = RstMinSpeed;
      lim_spd_hi = RstMaxSpeed;
      pos_y      = '0;
      pos_z      = '0;
      expected_moves.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgMaxY:     lim_y      = cfg_data[TgtW-1:0];
          CfgMaxZ:     lim_z      = cfg_data[TgtW-1:0];
          CfgMinSpeed: lim_spd_lo = cfg_data[SpdW-1:0];
          CfgMaxSpeed: lim_spd_hi = cfg_data[SpdW-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_moves.size() == 0) report_mismatch("result with no request waiting");
        else check_result(expected_moves.pop_front());
      end
      if (in_tvalid && in_tready)
        expected_moves.push_back(plan_move(in_tdata[9:0], in_tdata[19:10],
                                           in_tdata[27:20], in_tuser));
      pending <= expected_moves.size();
    end
  end

endmodule

// File: sim/two_axis_stepper_move_planner_core_test.sv
// two_axis_stepper_move_planner_core_test: drives move requests and limit
// writes into the planner with random idling on both streams; move_plan_checker
// does the prediction and comparison. Depends on mpp_pkg and the planner core.
`timescale 1ns / 100ps

module two_axis_stepper_move_planner_core_test;
  import mpp_pkg::*;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;
  int                  fail_count;
  int                  pending;

  bit              in_quiet  = 1'b0;
  bit              out_quiet = 1'b0;
  logic [TgtW-1:0] cur_max_y = RstMaxY;
  logic [TgtW-1:0] cur_max_z = RstMaxZ;
  logic [SpdW-1:0] cur_min_spd = RstMinSpeed;
  logic [SpdW-1:0] cur_max_spd = RstMaxSpeed;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  two_axis_stepper_move_planner_core u_dut (.*);

  move_plan_checker u_check (.*);

  // valid stays high across back-to-back transfers, lowered only for a gap
  task automatic send_move(input logic [TgtW-1:0] ty, input logic [TgtW-1:0] tz,
                           input logic [SpdW-1:0] spd, input logic sw);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, spd, tz, ty};
    in_tuser  <= sw;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_moves_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_limits(input logic [TgtW-1:0] y, input logic [TgtW-1:0] z,
                            input logic [SpdW-1:0] lo, input logic [SpdW-1:0] hi);
    cfg_valid <= 1'b1;
    write_reg(CfgMaxY, y);
    write_reg(CfgMaxZ, z);
    write_reg(CfgMinSpeed, {2'b0, lo});
    write_reg(CfgMaxSpeed, {2'b0, hi});
    cfg_valid   <= 1'b0;
    cur_max_y   = y;
    cur_max_z   = z;
    cur_min_spd = lo;
    cur_max_spd = hi;
  endtask

  // result side: sometimes stalls before the result shows, sometimes after
  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = out_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!out_tvalid);
        end
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    logic [TgtW-1:0] ty, tz, last_y, last_z;
    logic [SpdW-1:0] spd, lo, hi;
    int roll;
    last_y = '0;
    last_z = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: no motion, limit edges, each rejection, single-axis moves
    send_move(0, 0, 3, 1'b1);
    send_move(300, 100, 100, 1'b1);
    send_move(300, 100, 3, 1'b1);
    send_move(301, 0, 50, 1'b1);
    send_move(0, 101, 50, 1'b1);
    send_move(10, 10, 2, 1'b1);
    send_move(10, 10, 101, 1'b1);
    send_move(10, 10, 50, 1'b0);
    send_move(0, 0, 100, 1'b1);
    send_move(1, 0, 100, 1'b1);
    send_move(1, 1, 100, 1'b1);
    send_move(0, 0, 3, 1'b1);
    wait_moves_done();

    // full range: largest targets at the slowest and fastest speeds, single-axis moves
    set_limits(1023, 1023, 1, 255);
    send_move(1023, 1023, 1, 1'b1);
    send_move(0, 0, 255, 1'b1);
    send_move(1023, 0, 255, 1'b1);
    send_move(0, 1023, 1, 1'b1);
    send_move(512, 341, 0, 1'b1);
    send_move(0, 0, 255, 1'b1);
    wait_moves_done();

    // zero speed accepted: no divisor, both periods at their ceiling
    set_limits(1023, 1023, 0, 0);
    send_move(100, 200, 0, 1'b1);
    send_move(100, 200, 1, 1'b1);
    wait_moves_done();

    // min speed above max speed rejects everything
    set_limits(0, 0, 255, 1);
    send_move(0, 0, 200, 1'b1);
    send_move(0, 0, 1, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      wait_moves_done();
      case (ph)
        0: set_limits(1023, 1023, 1, 255);
        1: set_limits(RstMaxY, RstMaxZ, RstMinSpeed, RstMaxSpeed);
        2: set_limits(0, 1023, 255, 255);
        default: begin
          lo = $urandom_range(1, 120);
          hi = $urandom_range(lo, 255);
          set_limits($urandom_range(0, 1023), $urandom_range(0, 1023), lo, hi);
        end
      endcase
      for (int n = 0; n < 125; n++) begin
        if (n % 40 == 0) begin
          in_quiet  = ($urandom_range(0, 2) == 0);
          out_quiet = ($urandom_range(0, 2) == 0);
        end
        if ($urandom_range(0, 39) == 0) wait_moves_done();
        roll = $urandom_range(0, 19);
        ty  = (roll == 0) ? $urandom_range(0, 1023) : $urandom_range(0, cur_max_y);
        tz  = (roll == 1) ? $urandom_range(0, 1023) : $urandom_range(0, cur_max_z);
        spd = (roll == 2) ? $urandom_range(0, 255)
                          : $urandom_range(cur_min_spd, cur_max_spd);
        if (roll == 4) begin
          ty = last_y;
          tz = last_z;
        end
        send_move(ty, tz, spd, roll != 3);
        last_y = ty;
        last_z = tz;
      end
    end

    wait_moves_done();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("two_axis_stepper_move_planner_core_test OK");
    end else begin
      $display("two_axis_stepper_move_planner_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("two_axis_stepper_move_planner_core_test NOT OK");
    $finish;
  end

endmodule

// File: sim.f
rtl/mpp_pkg.sv
rtl/mpp_front.sv
rtl/mpp_fifo.sv
rtl/mpp_div.sv
rtl/mpp_back.sv
rtl/two_axis_stepper_move_planner_core.sv
rtl/mpp_checker.sv
sim/move_plan_checker.sv
sim/two_axis_stepper_move_planner_core_test.sv
